[rtl/hln_pkg.sv]
package hln_pkg;

    // Character codes used by the normalizer.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Default depth of the queue between the front and back parts.
    localparam int HLN_QUEUE_DEPTH = 4;

    // Line state of the front part.
    typedef enum logic [1:0] {
        MODE_COPY     = 2'd0,
        MODE_AFTER_CR = 2'd1,
        MODE_LWS      = 2'd2,
        MODE_BODY     = 2'd3
    } hln_mode_t;

    // One queue entry: the one or two results caused by one input item.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       end0;
        logic [7:0] byte1;
        logic       end1;
    } hln_cmd_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } hln_q_status_t;

endpackage

[rtl/hln_front.sv]
module hln_front
    import hln_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          end_of_stream,
    input  hln_q_status_t q_status,
    output logic          push,
    output hln_cmd_t      cmd
);

    hln_mode_t mode_reg, mode_next;
    logic      last_nl_reg, last_nl_next;
    logic      held_reg, held_next;

    logic in_fire;
    logic is_line_end;
    logic is_blank;
    logic resolve_held;
    logic cmd_valid;

    // An item is taken whenever the queue has room for its results.
    assign in_stall = q_status.full;
    assign in_fire  = in_valid && !in_stall;

    assign is_line_end  = (in_byte == CH_CR) || (in_byte == CH_LF);
    assign is_blank     = (in_byte == CH_SP) || (in_byte == CH_TAB);
    assign resolve_held = ((mode_reg == MODE_AFTER_CR) && (in_byte != CH_LF))
                          || (mode_reg == MODE_LWS);

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_COPY;
            last_nl_reg <= 1'b0;
            held_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            last_nl_reg <= last_nl_next;
            held_reg    <= held_next;
        end
    end

    // Next state.
    always_comb
    begin
        mode_next    = mode_reg;
        last_nl_next = last_nl_reg;
        held_next    = held_reg;
        if (in_fire)
        begin
            if (end_of_stream)
            begin
                if ((mode_reg != MODE_BODY) && held_reg)
                begin
                    held_next    = 1'b0;
                    last_nl_next = 1'b1;
                    mode_next    = MODE_COPY;
                end
            end
            else if (mode_reg == MODE_COPY)
            begin
                if (is_line_end)
                begin
                    if (last_nl_reg)
                    begin
                        mode_next = MODE_BODY;
                        held_next = 1'b0;
                    end
                    else
                    begin
                        held_next    = 1'b1;
                        last_nl_next = 1'b1;
                        mode_next    = (in_byte == CH_CR) ? MODE_AFTER_CR : MODE_LWS;
                    end
                end
                else
                begin
                    last_nl_next = 1'b0;
                end
            end
            else if ((mode_reg == MODE_AFTER_CR) && (in_byte == CH_LF))
            begin
                // The LF of a CR-LF pair is swallowed; the held LF may still fold.
                mode_next = MODE_LWS;
            end
            else if (resolve_held)
            begin
                held_next = 1'b0;
                if (is_blank)
                begin
                    last_nl_next = 1'b0;
                    mode_next    = MODE_COPY;
                end
                else if (is_line_end)
                begin
                    last_nl_next = 1'b1;
                    mode_next    = MODE_BODY;
                end
                else
                begin
                    last_nl_next = 1'b0;
                    mode_next    = MODE_COPY;
                end
            end
        end
    end

    // Results of the item, packed into one queue entry.
    always_comb
    begin
        cmd_valid = 1'b0;
        cmd.two   = 1'b0;
        cmd.byte0 = CH_LF;
        cmd.end0  = 1'b0;
        cmd.byte1 = CH_NUL;
        cmd.end1  = 1'b0;
        if (end_of_stream)
        begin
            cmd_valid = (mode_reg != MODE_BODY) && held_reg;
        end
        else if (mode_reg == MODE_COPY)
        begin
            if (is_line_end)
            begin
                cmd_valid = last_nl_reg;
                cmd.end0  = 1'b1;
            end
            else
            begin
                cmd_valid = 1'b1;
                cmd.byte0 = in_byte;
            end
        end
        else if (resolve_held)
        begin
            cmd_valid = 1'b1;
            if (is_blank)
            begin
                cmd.byte0 = CH_SP;
            end
            else
            begin
                // The held LF goes out first, then the byte as in copy mode.
                cmd.two   = 1'b1;
                cmd.byte1 = is_line_end ? CH_LF : in_byte;
                cmd.end1  = is_line_end;
            end
        end
    end

    assign push = in_fire && cmd_valid;

endmodule

[rtl/hln_queue.sv]
module hln_queue
    import hln_pkg::*;
#(
    parameter int DEPTH = HLN_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hln_cmd_t      push_cmd,
    input  logic          pop,
    output hln_cmd_t      head_cmd,
    output hln_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hln_cmd_t           entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/hln_back.sv]
module hln_back
    import hln_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  hln_q_status_t q_status,
    input  hln_cmd_t      head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          header_end,
    output logic          last_of_run
);

    logic       out_valid_reg;
    logic       second_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       last_reg;
    logic       load;

    // The output register takes a new result when it is empty or its transfer completes.
    assign load = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load && (!head_cmd.two || second_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                second_reg    <= head_cmd.two && !second_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, first or second half of the head entry.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (second_reg)
            begin
                byte_reg <= head_cmd.byte1;
                end_reg  <= head_cmd.end1;
                last_reg <= 1'b1;
            end
            else
            begin
                byte_reg <= head_cmd.byte0;
                end_reg  <= head_cmd.end0;
                last_reg <= !head_cmd.two;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign header_end  = end_reg;
    assign last_of_run = last_reg;

endmodule

[rtl/header_line_normalizer_unit.sv]
// Channel   Handshake            Payload
// input     in_valid / in_stall    in_byte[7:0], end_of_stream
// output    out_valid / out_stall  out_byte[7:0], header_end, last_of_run
//
// One input item is taken per cycle while the queue has room.
// Each result occupies the output register until its transfer, so an item with two results
// occupies the back part for two transfers; the queue absorbs such bursts.
// After its item's transfer, a result passes through a queue entry and then the output register.
// Reset clears the line state, the queue and the output register.
// A stalled output holds its result; input stalls only when the queue is full.
module header_line_normalizer_unit
    import hln_pkg::*;
#(
    parameter int QUEUE_DEPTH = HLN_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       header_end,
    output logic       last_of_run
);

    hln_q_status_t q_status;
    hln_cmd_t      push_cmd;
    hln_cmd_t      head_cmd;
    logic          push;
    logic          pop;

    // Front part: takes bytes and works out their results.
    hln_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .q_status      (q_status),
        .push          (push),
        .cmd           (push_cmd)
    );

    // Queue between the two parts.
    hln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back part: sends results one per transfer.
    hln_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .header_end  (header_end),
        .last_of_run (last_of_run)
    );

endmodule

[rtl/hln_checker.sv]
module hln_checker
    import hln_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       header_end,
    input logic       last_of_run
);

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(header_end) && $stable(last_of_run))
        else $error("stalled result changed");

    // The header end is always an LF and ends its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_end |-> (out_byte == CH_LF) && last_of_run)
        else $error("header end on a wrong result");

    // Nothing follows the header end transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && header_end |=> !out_valid)
        else $error("result after header end");

    // The first of two results is the plain held LF.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> (out_byte == CH_LF) && !header_end)
        else $error("first of two results is not a plain LF");

    // The second result follows its first without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("second result missing after first");

endmodule

bind header_line_normalizer_unit hln_checker u_hln_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .header_end  (header_end),
    .last_of_run (last_of_run)
);
